FILE: rtl/core/best_fit_free_block_allocator_assert.svh
// Assertion macros used by the allocator module.
`ifndef BEST_FIT_FREE_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_FREE_BLOCK_ALLOCATOR_ASSERT_SVH

// Assert that a condition implies a consequence in the same cycle.
`define BFA_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Assert that a condition implies a consequence in the next cycle.
`define BFA_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

    localparam int MaxRanges = 16;
    localparam int IdxW      = $clog2(MaxRanges);
    localparam int CntW      = $clog2(MaxRanges + 1);

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StNofit = 2'd1;
    localparam logic [1:0] StFull  = 2'd2;
    localparam logic [1:0] StRange = 2'd3;

    localparam logic CmdAdd   = 1'b0;
    localparam logic CmdAlloc = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] start_address;
        logic [16:0] length;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_address;
    } t_out_item;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] len;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_SWAP,
        S_OUT
    } t_state;

    // Controls from the sequencer to every cell in the row.
    typedef struct packed {
        logic   rotate;   // shift the ring by one place
        logic   write_en; // overwrite the cell at the head of the ring
        t_entry write_data;
    } t_ring_ctl;

endpackage
`default_nettype wire

FILE: rtl/core/bfa_cell.sv
`default_nettype none
module bfa_cell
    import bfa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_ring_ctl i_ctl,
    input  wire logic      i_head,
    input  wire t_entry    i_prev,
    output t_entry         o_entry
);

    t_entry r_entry;
    t_entry n_entry;

    // The head cell takes writes; all cells pass their entry on when rotating.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.rotate) begin
            n_entry = i_prev;
        end
        if (i_ctl.write_en && i_head) begin
            n_entry = i_ctl.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

FILE: rtl/core/bfa_ring.sv
`default_nettype none
module bfa_ring
    import bfa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_ring_ctl i_ctl,
    output t_entry         o_head
);

    t_entry w_entry [MaxRanges];

    // Cell k takes from cell k+1, so cell 0 always shows the next entry in turn.
    for (genvar k = 0; k < MaxRanges; k++) begin : g_cell
        bfa_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_head (k == 0),
            .i_prev (w_entry[(k + 1) % MaxRanges]),
            .o_entry(w_entry[k])
        );
    end

    assign o_head = w_entry[0];

endmodule
`default_nettype wire

FILE: rtl/core/best_fit_free_block_allocator.sv
// Best-fit free range allocator. The table of up to MaxRanges free ranges
// lives in a ring of identical cells that rotates by one place a cycle
// while scanning or writing; the sequencer only ever looks at the cell at
// the head. Every item is first accepted, then makes one full turn of the
// ring so the table is back in its original order afterwards; then the
// outcome is decided, a write pass of one more full turn follows when an
// entry changes (append, merge, trim or swap), and the result is presented.
// One item is worked on at a time; the output register holds the result
// until it is taken, and no new item is accepted while it waits.
`default_nettype none
module best_fit_free_block_allocator
    import bfa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_item     o_item
);

    t_state    r_state, n_state;
    t_in_item  r_req;
    logic [IdxW-1:0] r_pos, n_pos;      // index of the entry now at the head
    logic [CntW-1:0] r_count, n_count;
    logic      r_have, n_have;          // a match or best fit was found
    logic      r_done, n_done;          // scan stopped (merge or exact fit)
    logic [IdxW-1:0] r_sel, n_sel;
    t_entry    r_best, n_best;
    t_entry    r_last, n_last;          // entry at index count-1
    t_entry    r_newv, n_newv;          // new value for the selected entry
    logic      r_del, n_del;            // allocation emptied the entry
    logic [1:0] r_status, n_status;
    logic [15:0] r_grant, n_grant;
    logic      r_ovalid, n_ovalid;
    t_out_item r_out, n_out;
    t_ring_ctl w_ctl;
    t_entry    w_head;

    logic [16:0] w_end_new;
    logic [16:0] w_end_head;
    logic        w_in_range;
    logic        w_merge_hit, w_fit_hit;

    bfa_ring u_ring (
        .i_clk (i_clk),
        .i_ctl (w_ctl),
        .o_head(w_head)
    );

    assign w_end_new   = {1'b0, r_req.start_address} + r_req.length;
    assign w_end_head  = {1'b0, w_head.start} + w_head.len;
    assign w_in_range  = ({1'b0, r_pos} < {1'b0, r_count});
    assign w_merge_hit = w_in_range && (r_req.start_address >= w_head.start)
                         && ({1'b0, r_req.start_address} <= w_end_head);
    assign w_fit_hit   = w_in_range && (w_head.len >= r_req.length)
                         && (!r_have || r_best.len > w_head.len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_req    <= (r_state == S_IDLE && i_valid) ? i_item : r_req;
        r_pos    <= n_pos;
        r_have   <= n_have;
        r_done   <= n_done;
        r_sel    <= n_sel;
        r_best   <= n_best;
        r_last   <= n_last;
        r_newv   <= n_newv;
        r_del    <= n_del;
        r_status <= n_status;
        r_grant  <= n_grant;
        r_out    <= n_out;
    end

    always_comb begin
        n_state  = r_state;
        n_pos    = r_pos;
        n_count  = r_count;
        n_have   = r_have;
        n_done   = r_done;
        n_sel    = r_sel;
        n_best   = r_best;
        n_last   = r_last;
        n_newv   = r_newv;
        n_del    = r_del;
        n_status = r_status;
        n_grant  = r_grant;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_ctl    = '0;
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                n_pos  = '0;
                n_have = 1'b0;
                n_done = 1'b0;
                n_del  = 1'b0;
                n_sel  = '0;
                if (i_valid && !r_ovalid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // One entry a cycle passes the head; a full turn restores order.
                w_ctl.rotate = 1'b1;
                n_pos = r_pos + 1'b1;
                if ({1'b0, r_pos} == r_count - 1'b1) begin
                    n_last = w_head;
                end
                if (!r_done) begin
                    if (r_req.cmd == CmdAdd) begin
                        if (w_merge_hit) begin
                            n_have = 1'b1;
                            n_done = 1'b1;
                            n_sel  = r_pos;
                            n_best = w_head;
                        end
                    end else if (w_fit_hit) begin
                        n_have = 1'b1;
                        n_sel  = r_pos;
                        n_best = w_head;
                        n_done = (w_head.len == r_req.length);
                    end
                end
                if (r_pos == IdxW'(MaxRanges - 1)) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                // Decide the outcome and, if needed, start the write pass.
                n_pos   = '0;
                n_grant = '0;
                n_state = S_OUT;
                if (r_req.cmd == CmdAdd) begin
                    if (r_req.length == '0) begin
                        n_status = StOk;
                    end else if (w_end_new > 17'h10000 || w_end_new < r_req.length) begin
                        n_status = StRange;
                    end else if (r_have) begin
                        n_status = StOk;
                        if (w_end_new > {1'b0, r_best.start} + r_best.len) begin
                            n_newv.start = r_best.start;
                            n_newv.len   = w_end_new - {1'b0, r_best.start};
                            n_state      = S_SWAP;
                        end
                    end else if (r_count == CntW'(MaxRanges)) begin
                        n_status = StFull;
                    end else begin
                        n_status     = StOk;
                        n_sel        = r_count[IdxW-1:0];
                        n_newv.start = r_req.start_address;
                        n_newv.len   = r_req.length;
                        n_count      = r_count + 1'b1;
                        n_state      = S_SWAP;
                    end
                end else begin
                    if (r_req.length == '0 || !r_have) begin
                        n_status = StNofit;
                    end else begin
                        n_status     = StOk;
                        n_grant      = r_best.start;
                        n_newv.start = r_best.start + r_req.length[15:0];
                        n_newv.len   = r_best.len - r_req.length;
                        if (r_best.len == r_req.length) begin
                            n_del   = 1'b1;
                            n_newv  = r_last;
                            n_count = r_count - 1'b1;
                        end
                        n_state = S_SWAP;
                    end
                end
            end
            S_SWAP: begin
                // Turn once more. The write goes in on the cycle before the
                // selected entry would reach the head, so the new value takes
                // its place in the ring.
                w_ctl.rotate = 1'b1;
                n_pos = r_pos + 1'b1;
                if (n_pos == r_sel) begin
                    w_ctl.write_en   = 1'b1;
                    w_ctl.write_data = r_newv;
                end
                if (r_pos == IdxW'(MaxRanges - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    n_out.status          = r_status;
                    n_out.granted_address = r_grant;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Write at head with rotate: cell 0 takes write data, which lands at the
    // head position and then moves on with the ring like every other entry.

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    assign o_item  = r_out;

    `include "best_fit_free_block_allocator_assert.svh"

    `BFA_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CntW'(MaxRanges), "count over table size")
    `BFA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ovalid && i_stall, r_ovalid && $stable(r_out), "stalled result changed")
    `BFA_ASSERT_IMPL(a_grant_zero, i_clk, i_rst_n, r_ovalid && r_out.status != StOk, r_out.granted_address == '0, "grant without ok")
    `BFA_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, r_state == S_IDLE && i_valid && !o_stall, r_state == S_SCAN, "accepted item not scanned")

endmodule
`default_nettype wire
